// ----- hw/rtl/smooth_step_toward_target_core_macros.svh -----
// Assertion macros used by the checker file of the smooth step core.
`ifndef SMOOTH_STEP_TOWARD_TARGET_CORE_MACROS_SVH
`define SMOOTH_STEP_TOWARD_TARGET_CORE_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define SSTT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent, on every rising clock edge outside reset.
`define SSTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/sstt_pkg.sv -----
// Package with widths, register codes and control types of the smooth step core.
`default_nettype none

package sstt_pkg;

   localparam int DATA_W      = 16;
   localparam int CFG_W       = 15;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIVISOR_SCALE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_STEP      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_STEP      = 2'd2;

   localparam logic [CFG_W-1:0] SCALE_RESET    = 15'd1;
   localparam logic [CFG_W-1:0] MAX_STEP_RESET = 15'd32767;
   localparam logic [CFG_W-1:0] MIN_STEP_RESET = 15'd0;

   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   typedef struct packed {
      logic capture;
      logic div_step;
      logic clamp;
      logic add;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic skip;
   } ctl_sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sstt_channels.sv -----
// Valid/ready channel interfaces for the request and response items.
`default_nettype none

interface sstt_req_if;
   logic                             valid;
   logic                             ready;
   logic                             opcode;
   logic signed [sstt_pkg::DATA_W-1:0] target;

   modport source (output valid, output opcode, output target, input ready);
   modport sink   (input valid, input opcode, input target, output ready);
endinterface

interface sstt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [sstt_pkg::DATA_W-1:0] new_value;
   logic signed [sstt_pkg::DATA_W-1:0] distance_before;

   modport source (output valid, output new_value, output distance_before, input ready);
   modport sink   (input valid, input new_value, input distance_before, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sstt_datapath.sv -----
// Datapath: config registers, current value, serial divider, clamp and snap logic.
`default_nettype none

module sstt_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wen,
   input  wire logic [sstt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [sstt_pkg::CFG_W-1:0]         csr_wdata,
   input  wire logic                               in_opcode,
   input  wire logic signed [sstt_pkg::DATA_W-1:0] in_target,
   input  wire sstt_pkg::ctl_cmd_type              cmd,
   output sstt_pkg::ctl_sts_type                   sts,
   output logic signed [sstt_pkg::DATA_W-1:0]      out_new_value,
   output logic signed [sstt_pkg::DATA_W-1:0]      out_distance
);
   import sstt_pkg::*;

   logic [CFG_W-1:0]  scale_ff, max_ff, min_ff;
   logic [DATA_W-1:0] cur_ff, cur_in;
   logic [DATA_W-1:0] tgt_ff, tgt_in;
   logic [DATA_W-1:0] dist_ff, dist_in;
   logic              neg_ff, neg_in;
   logic              small_ff, small_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvd_ff, dvd_in;
   logic [DATA_W-1:0] delta_ff, delta_in;
   logic [DATA_W-1:0] sum_ff, sum_in;
   logic [DATA_W-1:0] new_ff, new_in;
   logic [DATA_W-1:0] dout_ff, dout_in;

   logic [DATA_W-1:0] dist_w, mag_w, trial_w, div_w, lim_w, mag_c, diff_w;
   logic              ge_w, big_w, over_w, snap_w;

   // A zero scale divides by one.
   assign div_w   = {1'b0, (scale_ff == '0) ? CFG_W'(1) : scale_ff};
   assign dist_w  = in_target - cur_ff;
   assign mag_w   = dist_w[DATA_W-1] ? (~dist_w + DATA_W'(1)) : dist_w;
   assign trial_w = {rem_ff[DATA_W-2:0], dvd_ff[DATA_W-1]};
   assign ge_w    = trial_w >= div_w;

   // After the division dvd_ff holds the magnitude of the quotient.
   assign big_w  = dvd_ff > {1'b0, min_ff};
   assign over_w = dvd_ff > {1'b0, max_ff};
   assign lim_w  = over_w ? {1'b0, max_ff} : dvd_ff;
   assign mag_c  = big_w ? lim_w : {1'b0, min_ff};

   // A minimum step snaps to the target when it reaches or passes it.
   assign diff_w = tgt_ff - sum_ff;
   assign snap_w = small_ff && (neg_ff ? !diff_w[DATA_W-1]
                                       : (diff_w[DATA_W-1] || diff_w == '0));

   assign sts.skip = in_opcode || (dist_w == '0);

   always_comb begin
      cur_in   = cur_ff;
      tgt_in   = tgt_ff;
      dist_in  = dist_ff;
      neg_in   = neg_ff;
      small_in = small_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      delta_in = delta_ff;
      sum_in   = sum_ff;
      new_in   = new_ff;
      dout_in  = dout_ff;
      if (cmd.capture) begin
         tgt_in   = in_target;
         dist_in  = in_opcode ? '0 : dist_w;
         neg_in   = dist_w[DATA_W-1];
         small_in = 1'b0;
         rem_in   = '0;
         dvd_in   = mag_w;
         sum_in   = in_opcode ? in_target : cur_ff;
      end
      if (cmd.div_step) begin
         rem_in = ge_w ? (trial_w - div_w) : trial_w;
         dvd_in = {dvd_ff[DATA_W-2:0], ge_w};
      end
      if (cmd.clamp) begin
         small_in = !big_w;
         delta_in = neg_ff ? (~mag_c + DATA_W'(1)) : mag_c;
      end
      if (cmd.add) begin
         sum_in = cur_ff + delta_ff;
      end
      if (cmd.finish) begin
         cur_in  = snap_w ? tgt_ff : sum_ff;
         new_in  = snap_w ? tgt_ff : sum_ff;
         dout_in = dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         max_ff   <= MAX_STEP_RESET;
         min_ff   <= MIN_STEP_RESET;
         cur_ff   <= '0;
      end else begin
         cur_ff <= cur_in;
         if (csr_wen) begin
            case (csr_index)
               CSR_DIVISOR_SCALE: scale_ff <= csr_wdata;
               CSR_MAX_STEP:      max_ff   <= csr_wdata;
               CSR_MIN_STEP:      min_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff   <= tgt_in;
      dist_ff  <= dist_in;
      neg_ff   <= neg_in;
      small_ff <= small_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      delta_ff <= delta_in;
      sum_ff   <= sum_in;
      new_ff   <= new_in;
      dout_ff  <= dout_in;
   end

   assign out_new_value = new_ff;
   assign out_distance  = dout_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sstt_controller.sv -----
// Controller: sequences capture, division, clamp, add and result hand-off.
`default_nettype none

module sstt_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   input  wire sstt_pkg::ctl_sts_type sts,
   output sstt_pkg::ctl_cmd_type      cmd
);
   import sstt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CLAMP,
      ST_ADD,
      ST_FIN
   } state_type;

   state_type            state_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 valid_ff;
   logic                 slot_free;

   assign slot_free    = !valid_ff || rsp_ready;
   assign req_ready    = (state_ff == ST_IDLE);
   assign cmd.capture  = req_valid && (state_ff == ST_IDLE);
   assign cmd.div_step = (state_ff == ST_DIV);
   assign cmd.clamp    = (state_ff == ST_CLAMP);
   assign cmd.add      = (state_ff == ST_ADD);
   assign cmd.finish   = (state_ff == ST_FIN) && slot_free;
   assign rsp_valid    = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (cmd.capture) begin
                  // Loads and zero distances need no division.
                  state_ff <= sts.skip ? ST_FIN : ST_DIV;
               end
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + DIV_CNT_W'(1);
               if (cnt_ff == DIV_LAST) begin
                  state_ff <= ST_CLAMP;
               end
            end
            ST_CLAMP: state_ff <= ST_ADD;
            ST_ADD:   state_ff <= ST_FIN;
            ST_FIN: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/smooth_step_toward_target_core.sv -----
// Top level of the smooth step core: controller, datapath and channel hookup.
//
//   channel   direction  payload                        handshake
//   req_ch    in         opcode, target                 valid/ready
//   rsp_ch    out        new_value, distance_before     valid/ready
//   csr_*     in         index, 15-bit data             write enable
//
// A step item passes from acceptance to result through a capture step, the
// restoring divider, then the clamp, add and snap steps. A load item or an
// item already at target skips the divider, clamp and add and goes to snap.
// One item is in work at a time; a finished result waits in the output register
// while the next item is accepted, and a stalled output holds only the last step.
// Reset is synchronous: current value zero, scale 1, max step 32767, min step 0.
`default_nettype none

module smooth_step_toward_target_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   sstt_req_if.sink                              req_ch,
   sstt_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_wen,
   input  wire logic [sstt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sstt_pkg::CFG_W-1:0]       csr_wdata
);
   import sstt_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   sstt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   sstt_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .in_opcode     (req_ch.opcode),
      .in_target     (req_ch.target),
      .cmd           (cmd),
      .sts           (sts),
      .out_new_value (rsp_ch.new_value),
      .out_distance  (rsp_ch.distance_before)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/sstt_checker.sv -----
// Port-level checker for the smooth step core and its bind to the top level.
`default_nettype none
`include "smooth_step_toward_target_core_macros.svh"

module sstt_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [sstt_pkg::DATA_W-1:0] new_value,
   input wire logic signed [sstt_pkg::DATA_W-1:0] distance_before
);
   import sstt_pkg::*;

   // A stalled result stays offered.
   `SSTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")

   // A stalled result keeps its payload.
   `SSTT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(new_value) && $stable(distance_before), "rsp payload changed while stalled")

   // Only one item is in work, so the request side closes after an accept.
   `SSTT_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready, "second item accepted while one is in work")

   // A new result appears only as the block returns to idle.
   `SSTT_ASSERT_IMPL(a_result_idle, clock, reset, $rose(rsp_valid), req_ready, "result raised while an item is still in work")

endmodule

bind smooth_step_toward_target_core sstt_checker u_sstt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .new_value       (rsp_ch.new_value),
   .distance_before (rsp_ch.distance_before)
);

`default_nettype wire

// ----- sim/smooth_step_toward_target_core_tb.sv -----
// Self-checking testbench for the smooth step core: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps

module smooth_step_toward_target_core_tb;
   import sstt_pkg::*;

   localparam logic OP_STEP = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam int SETTLE_CYCLES = 30;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 125;

   typedef struct packed {
      logic signed [DATA_W-1:0] new_value;
      logic signed [DATA_W-1:0] distance_before;
   } step_result_type;

   // Tracks the current value and settings of the core and queues the result of each item.
   class step_tracker;
      logic [CFG_W-1:0]         scale;
      logic [CFG_W-1:0]         max_step;
      logic [CFG_W-1:0]         min_step;
      logic signed [DATA_W-1:0] value;
      step_result_type          expected_q[$];
      int                       errors;

      function new();
         scale    = SCALE_RESET;
         max_step = MAX_STEP_RESET;
         min_step = MIN_STEP_RESET;
         value    = '0;
         errors   = 0;
      endfunction

      function void flag(input string msg);
         errors++;
         if (errors <= 10) begin
            $display("%s", msg);
         end
      endfunction

      function void note_request(input logic op, input logic signed [DATA_W-1:0] tgt);
         logic signed [DATA_W-1:0] distance;
         logic signed [DATA_W-1:0] next;
         logic signed [DATA_W-1:0] left;
         int                       div;
         int                       quo;
         int                       lo;
         int                       hi;
         distance = '0;
         next = value;
         if (op == OP_LOAD) begin
            next = tgt;
         end else begin
            distance = tgt - value;
            if (distance != 0) begin
               div = (scale == '0) ? 1 : int'(scale);
               quo = int'(distance) / div;
               lo  = int'(min_step);
               hi  = int'(max_step);
               if (quo > lo || quo < -lo) begin
                  if (quo > hi) quo = hi;
                  if (quo < -hi) quo = -hi;
                  next = value + DATA_W'(quo);
               end else if (distance > 0) begin
                  next = value + DATA_W'(lo);
                  left = tgt - next;
                  // Reaching or passing the target snaps onto it.
                  if (left <= 0) next = tgt;
               end else begin
                  next = value - DATA_W'(lo);
                  left = tgt - next;
                  if (left >= 0) next = tgt;
               end
            end
         end
         value = next;
         expected_q.push_back('{new_value: next, distance_before: distance});
      endfunction

      function void check_response(input logic signed [DATA_W-1:0] nv,
                                   input logic signed [DATA_W-1:0] distance);
         step_result_type want;
         if (expected_q.size() == 0) begin
            flag($sformatf("unexpected result: new_value %0d distance_before %0d",
                           nv, distance));
            return;
         end
         want = expected_q.pop_front();
         if (nv !== want.new_value || distance !== want.distance_before) begin
            flag($sformatf({"mismatch: new_value expected %0d got %0d, ",
                            "distance_before expected %0d got %0d"},
                           want.new_value, nv, want.distance_before, distance));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;
   bit   steady;
   int   idle_cycles = 0;

   sstt_req_if req_ch ();
   sstt_rsp_if rsp_ch ();

   step_tracker tracker = new();

   smooth_step_toward_target_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly back-to-back or short pauses, now and then a long one.
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [CFG_W-1:0] pick_setting(input logic [CFG_W-1:0] common);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return common;
         3: return CFG_W'($urandom_range(1, 8));
         4: return CFG_W'($urandom_range(1, 300));
         default: return CFG_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_goal();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return DATA_W'($urandom_range(0, 2)) - 16'sd1;
         3, 4: return tracker.value + DATA_W'($urandom_range(0, 64)) - 16'sd32;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // Leaves valid high after acceptance so that a zero pause keeps items back to back.
   task automatic push_item(input logic op, input logic signed [DATA_W-1:0] tgt);
      int pause;
      pause = pick_pause();
      if (pause > 0) begin
         req_ch.valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.target <= tgt;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_request(op, tgt);
   endtask

   task automatic wait_until_settled();
      while (tracker.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CFG_W-1:0] scale, input logic [CFG_W-1:0] max_s,
                                 input logic [CFG_W-1:0] min_s);
      req_ch.valid <= 1'b0;
      wait_until_settled();
      csr_wen   <= 1'b1;
      csr_index <= CSR_DIVISOR_SCALE;
      csr_wdata <= scale;
      @(posedge clock);
      csr_index <= CSR_MAX_STEP;
      csr_wdata <= max_s;
      @(posedge clock);
      csr_index <= CSR_MIN_STEP;
      csr_wdata <= min_s;
      @(posedge clock);
      csr_wen <= 1'b0;
      tracker.scale    = scale;
      tracker.max_step = max_s;
      tracker.min_step = min_s;
   endtask

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : receive_results
      int pause;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         pause = pick_pause();
         if (pause > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         tracker.check_response(rsp_ch.new_value, rsp_ch.distance_before);
      end
   end

   initial begin : drive_items
      logic signed [DATA_W-1:0] goal;
      int                       r;
      reset         = 1'b1;
      csr_wen       = 1'b0;
      csr_index     = CSR_DIVISOR_SCALE;
      csr_wdata     = '0;
      req_ch.valid  = 1'b0;
      req_ch.opcode = OP_STEP;
      req_ch.target = '0;
      steady        = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Settings straight out of reset: already at target, wrapped distances,
      // and the full negative distance clamped to the largest step.
      push_item(OP_STEP, 16'sd0);
      push_item(OP_STEP, 16'sh7FFF);
      push_item(OP_STEP, 16'sh8000);
      push_item(OP_LOAD, 16'sh7FFF);
      push_item(OP_STEP, 16'sh8000);
      push_item(OP_LOAD, 16'sd0);
      push_item(OP_STEP, 16'sh8000);
      push_item(OP_LOAD, -16'sd1);
      push_item(OP_STEP, 16'sd1);

      // A zero scale acts as one; a zero largest step freezes the value.
      apply_settings('0, '0, '0);
      push_item(OP_LOAD, 16'sd5);
      push_item(OP_STEP, 16'sd100);
      push_item(OP_STEP, 16'sh8000);

      // Quotients round to zero, and a zero smallest step does not move.
      apply_settings('1, '1, '0);
      push_item(OP_STEP, 16'sd1000);
      push_item(OP_LOAD, 16'sd0);
      push_item(OP_STEP, 16'sh8000);

      // Huge smallest step always overshoots and snaps, also across the wrap.
      apply_settings('1, 15'd1, '1);
      push_item(OP_LOAD, 16'sd0);
      push_item(OP_STEP, 16'sd10);
      push_item(OP_STEP, -16'sd10);
      push_item(OP_LOAD, 16'sh8000);
      push_item(OP_STEP, 16'sh7FFF);

      // Clamped proportional step, exact landing, overshoot snap, negative small step.
      apply_settings(15'd4, 15'd3, 15'd2);
      push_item(OP_LOAD, 16'sd0);
      push_item(OP_STEP, 16'sd100);
      push_item(OP_STEP, 16'sd5);
      push_item(OP_STEP, 16'sd6);
      push_item(OP_LOAD, 16'sd0);
      push_item(OP_STEP, -16'sd7);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase % 4 == 0) begin
            apply_settings(pick_setting(15'd1), pick_setting('1), pick_setting('0));
         end else begin
            apply_settings(pick_setting(CFG_W'($urandom_range(1, 16))),
                           pick_setting(CFG_W'($urandom_range(1, 2000))),
                           pick_setting(CFG_W'($urandom_range(0, 20))));
         end
         steady = ($urandom_range(0, 3) == 0);
         goal   = pick_goal();
         // Runs of steps toward one goal, broken by loads, new goals and stray targets.
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               push_item(OP_LOAD, DATA_W'($urandom));
            end else if (r < 20) begin
               goal = pick_goal();
               push_item(OP_STEP, goal);
            end else if (r < 25) begin
               push_item(OP_STEP, DATA_W'($urandom));
            end else begin
               push_item(OP_STEP, goal);
            end
         end
      end

      req_ch.valid <= 1'b0;
      wait_until_settled();
      if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// ----- smooth_step_toward_target_core.f -----
+incdir+hw/rtl
hw/rtl/sstt_pkg.sv
hw/rtl/sstt_channels.sv
hw/rtl/sstt_datapath.sv
hw/rtl/sstt_controller.sv
hw/rtl/smooth_step_toward_target_core.sv
hw/rtl/sstt_checker.sv
sim/smooth_step_toward_target_core_tb.sv
